[rtl/cylinder_placement_matrix_unit_assert.svh]
// ----------------------------------------------------------------------------
// Cylinder placement matrix unit - assertion macros
// Concurrent checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CYLINDER_PLACEMENT_MATRIX_UNIT_ASSERT_SVH
`define CYLINDER_PLACEMENT_MATRIX_UNIT_ASSERT_SVH

// a implies b in the same cycle
`define CPM_ASSERT_NOW(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) else $error(msg);

// a implies b a fixed number of cycles later
`define CPM_ASSERT_LAT(lbl, a, n, b, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> ##n (b)) \
    else $error(msg);

`endif

[rtl/cpm_pkg.sv]
// ----------------------------------------------------------------------------
// cpm_pkg
// Item types and fixed-point constants of the cylinder placement matrix unit.
// ----------------------------------------------------------------------------
package cpm_pkg;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
    logic [31:0]        radius;
    logic               last_in;
  } cpm_in_t;

  typedef struct packed {
    logic signed [47:0] m00;
    logic signed [47:0] m01;
    logic signed [47:0] m02;
    logic signed [47:0] m10;
    logic signed [47:0] m11;
    logic signed [47:0] m12;
    logic signed [47:0] m20;
    logic signed [47:0] m21;
    logic signed [47:0] m22;
    logic               last_out;
  } cpm_out_t;

  localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;
  localparam logic signed [31:0] Q30_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q30_MIN = 32'sh8000_0000;
  localparam int                 QBITS   = 32;

endpackage

[rtl/cpm_front.sv]
// ----------------------------------------------------------------------------
// cpm_front
// Takes an item, forms the axis components, their signs and magnitudes and
// flags a zero-length axis.
// ----------------------------------------------------------------------------
module cpm_front #(
  parameter int CW = 32,
  parameter int EW = 3 * CW + 40
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cpm_pkg::cpm_in_t item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [EW-1:0]    out_data_o
);
  import cpm_pkg::*;

  localparam int MW = CW + 1;

  typedef struct packed {
    logic [2:0]          sgn;
    logic [2:0][MW-1:0]  mag;
    logic                zero;
    logic [31:0]         radius;
    logic                last;
  } fe_t;

  function automatic logic [CW-1:0] coord(input logic [31:0] f);
    logic [63:0] p;
    p = {32'b0, f};
    return p[CW-1:0];
  endfunction

  function automatic logic [CW:0] diff(input logic [31:0] a, input logic [31:0] b);
    logic [CW-1:0] ca;
    logic [CW-1:0] cb;
    ca = coord(a);
    cb = coord(b);
    return {ca[CW-1], ca} - {cb[CW-1], cb};
  endfunction

  logic            valid_q;
  logic            take;
  fe_t             data_q;
  fe_t             data_d;
  logic [2:0][CW:0] v;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign take        = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_comb begin
    v[0] = diff(item_i.end_x, item_i.start_x);
    v[1] = diff(item_i.end_y, item_i.start_y);
    v[2] = diff(item_i.end_z, item_i.start_z);
    for (int i = 0; i < 3; i++) begin
      data_d.sgn[i] = v[i][CW];
      data_d.mag[i] = v[i][CW] ? (~v[i] + 1'b1) : v[i];
    end
    data_d.zero   = (v[0] == '0) && (v[1] == '0) && (v[2] == '0);
    data_d.radius = item_i.radius;
    data_d.last   = item_i.last_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= take || (valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= data_d;
    end
  end

endmodule

[rtl/cpm_queue.sv]
// ----------------------------------------------------------------------------
// cpm_queue
// Two-entry queue between front and back; the back drains one item a cycle.
// ----------------------------------------------------------------------------
module cpm_queue #(
  parameter int W = 136
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         ready_o,
  output logic         valid_o,
  output logic [W-1:0] data_o
);
  import cpm_pkg::*;

  logic [W-1:0] mem_q [2];
  logic         wr_q;
  logic         rd_q;
  logic [1:0]   cnt_q;
  logic         push;
  logic         pop;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign push    = push_i && ready_o;
  assign pop     = valid_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= !wr_q;
      end
      if (pop) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

[rtl/cpm_back.sv]
// ----------------------------------------------------------------------------
// cpm_back
// Pipelined datapath: axis length by bit-serial root, unit vector by
// restoring division, rotation terms, radius and length scaling.
// ----------------------------------------------------------------------------
module cpm_back #(
  parameter int CW = 32,
  parameter int EW = 3 * CW + 40
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [EW-1:0]     in_data_i,
  output logic              out_valid_o,
  output cpm_pkg::cpm_out_t out_o
);
  import cpm_pkg::*;

  localparam int MW = CW + 1;
  localparam int SW = 2 * MW + 2;
  localparam int DW = SW / 2;
  localparam int RW = DW + 3;
  localparam int FW = (DW > 32) ? DW : 32;
  localparam int OW = (FW + 2 > 48) ? FW + 2 : 48;

  typedef struct packed {
    logic [2:0]          sgn;
    logic [2:0][MW-1:0]  mag;
    logic                zero;
    logic [31:0]         radius;
    logic                last;
  } fe_t;

  typedef struct packed {
    logic [2:0]  sgn;
    logic        zero;
    logic [31:0] radius;
    logic        last;
  } sb_t;

  typedef struct packed {
    logic [2:0][2*MW-1:0] sq;
    logic [2:0][MW-1:0]   mag;
    sb_t                  sb;
  } s0_t;

  typedef struct packed {
    logic [RW-1:0]       rem;
    logic [DW-1:0]       root;
    logic [SW-1:0]       s;
    logic [2:0][MW-1:0]  mag;
    sb_t                 sb;
  } sq_t;

  typedef struct packed {
    logic [2:0][DW:0]  r;
    logic [2:0][31:0]  q;
    logic [DW-1:0]     d;
    sb_t               sb;
  } dv_t;

  typedef struct packed {
    logic signed [31:0] c;
    logic signed [31:0] wx;
    logic signed [31:0] wy;
    logic [DW-1:0]      d;
    logic [31:0]        radius;
    logic               last;
  } un_t;

  typedef struct packed {
    logic               nxy;
    logic               den_pos;
    logic [31:0]        den;
    logic signed [31:0] c;
    logic signed [31:0] wx;
    logic signed [31:0] wy;
    logic [DW-1:0]      d;
    logic [31:0]        radius;
    logic               last;
  } tl_t;

  typedef struct packed {
    logic [2:0][61:0] m;
    tl_t              tl;
  } pm_t;

  typedef struct packed {
    logic [2:0][32:0] r;
    logic [2:0][31:0] lo;
    logic [2:0][31:0] q;
    logic [2:0]       ovf;
    tl_t              tl;
  } rt_t;

  typedef struct packed {
    logic signed [31:0] e00;
    logic signed [31:0] pxy;
    logic signed [31:0] e11;
    tl_t                tl;
  } en_t;

  typedef struct packed {
    logic [8:0][FW+31:0] p;
    logic [8:0]          neg;
    logic                last;
  } mo_t;

  function automatic sq_t sq_step(input sq_t a);
    logic [RW-1:0] sh;
    logic [RW-1:0] t;
    logic          ge;
    sq_t           n;
    n      = a;
    sh     = {a.rem[RW-3:0], a.s[SW-1:SW-2]};
    t      = {1'b0, a.root, 2'b01};
    ge     = (sh >= t);
    n.rem  = ge ? (sh - t) : sh;
    n.root = {a.root[DW-2:0], ge};
    n.s    = {a.s[SW-3:0], 2'b00};
    return n;
  endfunction

  function automatic dv_t dv_step(input dv_t a, input logic first);
    logic [DW:0] val;
    logic        ge;
    dv_t         n;
    n = a;
    for (int i = 0; i < 3; i++) begin
      val       = first ? a.r[i] : {a.r[i][DW-1:0], 1'b0};
      ge        = (val >= {1'b0, a.d});
      n.r[i]    = ge ? (val - {1'b0, a.d}) : val;
      n.q[i]    = {a.q[i][30:0], ge};
    end
    return n;
  endfunction

  function automatic rt_t rt_step(input rt_t a);
    logic [32:0] val;
    logic        ge;
    rt_t         n;
    n = a;
    for (int i = 0; i < 3; i++) begin
      val     = {a.r[i][31:0], a.lo[i][31]};
      ge      = (val >= {1'b0, a.tl.den});
      n.r[i]  = ge ? (val - {1'b0, a.tl.den}) : val;
      n.lo[i] = {a.lo[i][30:0], 1'b0};
      n.q[i]  = {a.q[i][30:0], ge};
    end
    return n;
  endfunction

  function automatic logic signed [31:0] unit_val(input logic [31:0] q, input logic neg);
    logic [32:0] qr;
    qr = ({1'b0, q} + 33'd1) >> 1;
    return neg ? -qr[31:0] : qr[31:0];
  endfunction

  function automatic logic signed [31:0] sat_ratio(input logic [31:0] q, input logic ovf,
                                                   input logic neg, input logic ok);
    logic signed [31:0] r;
    if (!ok) begin
      r = '0;
    end else if (neg) begin
      r = (ovf || (q > 32'h8000_0000)) ? Q30_MIN : -q;
    end else begin
      r = (ovf || q[31]) ? Q30_MAX : q;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      return s[32] ? Q30_MIN : Q30_MAX;
    end
    return s[31:0];
  endfunction

  fe_t              ent;
  s0_t              s0_q;
  s0_t              s0_d;
  logic             s0_v_q;
  sq_t              sqp_q [DW+1];
  sq_t              sqp_d [DW];
  sq_t              sq_in;
  logic [DW:0]      sqv_q;
  dv_t              dvp_q [QBITS+1];
  dv_t              dvp_d [QBITS];
  dv_t              dv_in;
  logic [QBITS:0]   dvv_q;
  un_t              un_q;
  un_t              un_d;
  logic             un_v_q;
  pm_t              pm_q;
  pm_t              pm_d;
  logic             pm_v_q;
  rt_t              rtp_q [QBITS+1];
  rt_t              rtp_d [QBITS];
  rt_t              rt_in;
  logic [QBITS:0]   rtv_q;
  en_t              en_q;
  en_t              en_d;
  logic             en_v_q;
  mo_t              mo_q;
  mo_t              mo_d;
  logic             mo_v_q;
  cpm_out_t         out_q;
  cpm_out_t         out_d;
  logic             out_v_q;

  logic signed [31:0] ux_w;
  logic signed [31:0] uy_w;
  logic [31:0]        ax_w;
  logic [31:0]        ay_w;
  logic [32:0]        den_w;
  logic [63:0]        n_w [3];
  logic signed [31:0] px_w;
  logic signed [31:0] py_w;
  logic signed [31:0] ev_w [9];
  logic [FW-1:0]      fv_w [9];
  logic [31:0]        mv_w [9];
  logic [FW+31:0]     pr_w [9];
  logic [OW-1:0]      qe_w [9];
  logic [OW-1:0]      lim_w [9];
  logic [47:0]        qs_w [9];
  logic [8:0][47:0]   res_w;

  assign ent = fe_t'(in_data_i);

  // squares
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s0_d.sq[i] = (2*MW)'(ent.mag[i]) * (2*MW)'(ent.mag[i]);
    end
    s0_d.mag       = ent.mag;
    s0_d.sb.sgn    = ent.sgn;
    s0_d.sb.zero   = ent.zero;
    s0_d.sb.radius = ent.radius;
    s0_d.sb.last   = ent.last;
  end

  // root, one result bit per stage
  always_comb begin
    sq_in.rem  = '0;
    sq_in.root = '0;
    sq_in.s    = SW'(s0_q.sq[0]) + SW'(s0_q.sq[1]) + SW'(s0_q.sq[2]);
    sq_in.mag  = s0_q.mag;
    sq_in.sb   = s0_q.sb;
    for (int k = 0; k < DW; k++) begin
      sqp_d[k] = sq_step(sqp_q[k]);
    end
  end

  // unit vector, one quotient bit per stage
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_in.r[i] = (DW+1)'(sqp_q[DW].mag[i]);
      dv_in.q[i] = '0;
    end
    dv_in.d  = sqp_q[DW].root;
    dv_in.sb = sqp_q[DW].sb;
    for (int k = 0; k < QBITS; k++) begin
      dvp_d[k] = dv_step(dvp_q[k], (k == 0));
    end
  end

  always_comb begin
    ux_w = unit_val(dvp_q[QBITS].q[0], dvp_q[QBITS].sb.sgn[0]);
    uy_w = unit_val(dvp_q[QBITS].q[1], dvp_q[QBITS].sb.sgn[1]);
    if (dvp_q[QBITS].sb.zero) begin
      un_d.c  = Q30_ONE;
      un_d.wx = '0;
      un_d.wy = '0;
    end else begin
      un_d.c  = unit_val(dvp_q[QBITS].q[2], dvp_q[QBITS].sb.sgn[2]);
      un_d.wx = -uy_w;
      un_d.wy = ux_w;
    end
    un_d.d      = dvp_q[QBITS].d;
    un_d.radius = dvp_q[QBITS].sb.radius;
    un_d.last   = dvp_q[QBITS].sb.last;
  end

  // w products and 1 + c
  always_comb begin
    ax_w  = un_q.wx[31] ? -un_q.wx : un_q.wx;
    ay_w  = un_q.wy[31] ? -un_q.wy : un_q.wy;
    den_w = {1'b0, Q30_ONE} + {un_q.c[31], un_q.c};
    pm_d.m[0]      = 62'(ax_w[30:0]) * 62'(ax_w[30:0]);
    pm_d.m[1]      = 62'(ax_w[30:0]) * 62'(ay_w[30:0]);
    pm_d.m[2]      = 62'(ay_w[30:0]) * 62'(ay_w[30:0]);
    pm_d.tl.nxy     = un_q.wx[31] ^ un_q.wy[31];
    pm_d.tl.den_pos = !den_w[32] && (den_w != '0);
    pm_d.tl.den     = den_w[31:0];
    pm_d.tl.c       = un_q.c;
    pm_d.tl.wx      = un_q.wx;
    pm_d.tl.wy      = un_q.wy;
    pm_d.tl.d       = un_q.d;
    pm_d.tl.radius  = un_q.radius;
    pm_d.tl.last    = un_q.last;
  end

  // ratio division: half the divisor added for rounding, large quotients flagged
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_w[i]        = 64'(pm_q.m[i]) + 64'(pm_q.tl.den[31:1]);
      rt_in.ovf[i]  = (n_w[i] >= {pm_q.tl.den, 32'b0});
      rt_in.r[i]    = {1'b0, n_w[i][63:32]};
      rt_in.lo[i]   = n_w[i][31:0];
      rt_in.q[i]    = '0;
    end
    rt_in.tl = pm_q.tl;
    for (int k = 0; k < QBITS; k++) begin
      rtp_d[k] = rt_step(rtp_q[k]);
    end
  end

  always_comb begin
    px_w = sat_ratio(rtp_q[QBITS].q[0], rtp_q[QBITS].ovf[0], 1'b0,
                     rtp_q[QBITS].tl.den_pos);
    py_w = sat_ratio(rtp_q[QBITS].q[2], rtp_q[QBITS].ovf[2], 1'b0,
                     rtp_q[QBITS].tl.den_pos);
    en_d.pxy = sat_ratio(rtp_q[QBITS].q[1], rtp_q[QBITS].ovf[1], rtp_q[QBITS].tl.nxy,
                         rtp_q[QBITS].tl.den_pos);
    en_d.e00 = add_sat(px_w, rtp_q[QBITS].tl.c);
    en_d.e11 = add_sat(py_w, rtp_q[QBITS].tl.c);
    en_d.tl  = rtp_q[QBITS].tl;
  end

  // scaling
  always_comb begin
    ev_w[0] = en_q.e00;
    ev_w[1] = en_q.pxy;
    ev_w[2] = -en_q.tl.wy;
    ev_w[3] = en_q.pxy;
    ev_w[4] = en_q.e11;
    ev_w[5] = en_q.tl.wx;
    ev_w[6] = en_q.tl.wy;
    ev_w[7] = -en_q.tl.wx;
    ev_w[8] = en_q.tl.c;
    for (int i = 0; i < 9; i++) begin
      fv_w[i] = (i < 6) ? FW'(en_q.tl.radius) : FW'(en_q.tl.d);
      mv_w[i] = ev_w[i][31] ? -ev_w[i] : ev_w[i];
      mo_d.p[i]   = (FW+32)'(fv_w[i]) * (FW+32)'(mv_w[i]);
      mo_d.neg[i] = ev_w[i][31];
    end
    mo_d.last = en_q.tl.last;
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      pr_w[i]  = mo_q.p[i] + (FW+32)'(32'h2000_0000);
      qe_w[i]  = OW'(pr_w[i][FW+31:30]);
      lim_w[i] = mo_q.neg[i] ? (OW'(1) << 47) : ((OW'(1) << 47) - OW'(1));
      qs_w[i]  = (qe_w[i] > lim_w[i]) ? lim_w[i][47:0] : qe_w[i][47:0];
      res_w[i] = mo_q.neg[i] ? -qs_w[i] : qs_w[i];
    end
    out_d.m00      = res_w[0];
    out_d.m01      = res_w[1];
    out_d.m02      = res_w[2];
    out_d.m10      = res_w[3];
    out_d.m11      = res_w[4];
    out_d.m12      = res_w[5];
    out_d.m20      = res_w[6];
    out_d.m21      = res_w[7];
    out_d.m22      = res_w[8];
    out_d.last_out = mo_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q  <= 1'b0;
      sqv_q   <= '0;
      dvv_q   <= '0;
      un_v_q  <= 1'b0;
      pm_v_q  <= 1'b0;
      rtv_q   <= '0;
      en_v_q  <= 1'b0;
      mo_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s0_v_q  <= in_valid_i;
      sqv_q   <= {sqv_q[DW-1:0], s0_v_q};
      dvv_q   <= {dvv_q[QBITS-1:0], sqv_q[DW]};
      un_v_q  <= dvv_q[QBITS];
      pm_v_q  <= un_v_q;
      rtv_q   <= {rtv_q[QBITS-1:0], pm_v_q};
      en_v_q  <= rtv_q[QBITS];
      mo_v_q  <= en_v_q;
      out_v_q <= mo_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q     <= s0_d;
    sqp_q[0] <= sq_in;
    for (int k = 0; k < DW; k++) begin
      sqp_q[k+1] <= sqp_d[k];
    end
    dvp_q[0] <= dv_in;
    for (int k = 0; k < QBITS; k++) begin
      dvp_q[k+1] <= dvp_d[k];
    end
    un_q     <= un_d;
    pm_q     <= pm_d;
    rtp_q[0] <= rt_in;
    for (int k = 0; k < QBITS; k++) begin
      rtp_q[k+1] <= rtp_d[k];
    end
    en_q  <= en_d;
    mo_q  <= mo_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

endmodule

[rtl/cylinder_placement_matrix_unit.sv]
// ----------------------------------------------------------------------------
// Cylinder placement matrix unit
// Per cylinder: axis length, unit axis and the scaled rotation taking +z onto
// the axis, as the nine upper-left entries of the placement matrix.
//
//   channel   ports                          direction
//   item      start, busy, item_i            in (busy out)
//   result    result_valid_o, result_o       out
//
// One item a cycle is taken while busy is low; each result follows its item
// through the front register, the queue and a COORD_WIDTH + 75 stage back
// end, dominated by the bit-serial root and the two 32-step dividers.
// busy rises only when the two-entry queue is full and the front register
// holds an item; the back end drains one item every cycle.
// Reset clears all valid flags; no clearing pass. The receiver cannot stall.
// ----------------------------------------------------------------------------
`include "cylinder_placement_matrix_unit_assert.svh"

module cylinder_placement_matrix_unit #(
  parameter int COORD_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  cpm_pkg::cpm_in_t  item_i,
  output logic              busy,
  output logic              result_valid_o,
  output cpm_pkg::cpm_out_t result_o
);
  import cpm_pkg::*;

  localparam int EW  = 3 * COORD_WIDTH + 40;
  localparam int LAT = COORD_WIDTH + 75;

  logic          f_ready;
  logic          f_valid;
  logic [EW-1:0] f_data;
  logic          q_ready;
  logic          q_valid;
  logic [EW-1:0] q_data;

  assign busy = !f_ready;

  cpm_front #(
    .CW (COORD_WIDTH),
    .EW (EW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (start),
    .in_ready_o  (f_ready),
    .item_i      (item_i),
    .out_valid_o (f_valid),
    .out_ready_i (q_ready),
    .out_data_o  (f_data)
  );

  cpm_queue #(
    .W (EW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .data_i  (f_data),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  cpm_back #(
    .CW (COORD_WIDTH),
    .EW (EW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_data_i   (q_data),
    .out_valid_o (result_valid_o),
    .out_o       (result_o)
  );

  `CPM_ASSERT_LAT(a_item_yields_result, q_valid, LAT, result_valid_o, "item lost in back end")
  `CPM_ASSERT_NOW(a_result_has_item, result_valid_o, $past(q_valid, LAT), "result without item")
  `CPM_ASSERT_NOW(a_busy_only_when_full, busy, f_valid && !q_ready, "busy while queue has room")

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// Cylinder placement matrix unit - testbench
// Drives cylinders through the start/busy command port, computes the expected
// scaled rotation entries for each accepted item and checks every result strobe
// against the oldest pending matrix, in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cpm_pkg::*;

  localparam int CW        = 32;
  localparam int DRAIN     = CW + 90;
  localparam int WD_LIMIT  = 3000;
  localparam int N_RANDOM  = 730;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  cpm_in_t  item_i = '0;
  logic     busy;
  logic     result_valid_o;
  cpm_out_t result_o;

  cpm_out_t matrix_q[$];
  int       n_errors = 0;
  int       n_items = 0;
  int       n_results = 0;
  int       n_opposite = 0;
  int       n_zero_len = 0;
  int       idle_cnt = 0;

  cylinder_placement_matrix_unit #(.COORD_WIDTH(CW)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .item_i(item_i),
    .busy(busy), .result_valid_o(result_valid_o), .result_o(result_o)
  );

  always #6 clk_i = ~clk_i;

  // ---------------- predictor ----------------
  function automatic longint abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint sat_q30(longint v);
    if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  function automatic logic [63:0] isqrt(logic [127:0] s);
    logic [127:0] y, cand;
    y = '0;
    for (int b = 51; b >= 0; b--) begin
      cand = y | (128'd1 << b);
      if (cand * cand <= s) y = cand;
    end
    return y[63:0];
  endfunction

  function automatic longint unit_q30(longint comp, logic [63:0] d);
    logic [127:0] t;
    longint q;
    t = ({64'd0, abs64(comp)} << 31) / {64'd0, d};
    q = longint'((t + 128'd1) >> 1);
    return (comp < 0) ? -q : q;
  endfunction

  function automatic longint ratio_q30(longint a, longint b, longint den);
    longint num, q;
    num = a * b;
    q = (abs64(num) + den / 2) / den;
    return sat_q30((num < 0) ? -q : q);
  endfunction

  function automatic logic [47:0] scale_q16(logic [63:0] factor, longint e);
    logic [127:0] p, lim;
    logic [47:0]  q;
    p = {64'd0, factor} * {64'd0, abs64(e)} + (128'd1 << 29);
    p = p >> 30;
    lim = (e < 0) ? (128'd1 << 47) : ((128'd1 << 47) - 1);
    if (p > lim) p = lim;
    q = p[47:0];
    return (e < 0) ? -q : q;
  endfunction

  function automatic cpm_out_t placement_matrix(cpm_in_t it);
    longint vx, vy, vz, ux, uy, c, wx, wy, den, pxx, pxy, pyy;
    logic [127:0] s;
    logic [63:0]  d, r;
    cpm_out_t     m;
    vx = longint'(it.end_x) - longint'(it.start_x);
    vy = longint'(it.end_y) - longint'(it.start_y);
    vz = longint'(it.end_z) - longint'(it.start_z);
    r = {32'd0, it.radius};
    s = {64'd0, abs64(vx)} * {64'd0, abs64(vx)} + {64'd0, abs64(vy)} * {64'd0, abs64(vy)}
      + {64'd0, abs64(vz)} * {64'd0, abs64(vz)};
    d = isqrt(s);
    if (d == 0) begin
      ux = 0; uy = 0; c = longint'(Q30_ONE);
    end else begin
      ux = unit_q30(vx, d); uy = unit_q30(vy, d); c = unit_q30(vz, d);
    end
    wx = -uy;
    wy = ux;
    den = longint'(Q30_ONE) + c;
    if (den <= 0) begin
      pxx = 0; pxy = 0; pyy = 0;
    end else begin
      pxx = ratio_q30(wx, wx, den);
      pxy = ratio_q30(wx, wy, den);
      pyy = ratio_q30(wy, wy, den);
    end
    m.m00 = scale_q16(r, sat_q30(pxx + c));
    m.m01 = scale_q16(r, pxy);
    m.m02 = scale_q16(r, -wy);
    m.m10 = scale_q16(r, pxy);
    m.m11 = scale_q16(r, sat_q30(pyy + c));
    m.m12 = scale_q16(r, wx);
    m.m20 = scale_q16(d, wy);
    m.m21 = scale_q16(d, -wx);
    m.m22 = scale_q16(d, c);
    m.last_out = it.last_in;
    if (d == 0) n_zero_len++;
    if (den <= 0) n_opposite++;
    return m;
  endfunction

  // ---------------- checking ----------------
  task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] exp_v);
    n_errors++;
    $display("MISMATCH result %0d %s: got %h expected %h", n_results, what, got, exp_v);
  endtask

  always @(posedge clk_i) begin
    cpm_out_t e;
    if (rst_ni && result_valid_o) begin
      if (matrix_q.size() == 0) begin
        report_mismatch("unexpected result", result_o.m00, 48'd0);
      end else begin
        e = matrix_q.pop_front();
        if (result_o.m00 !== e.m00) report_mismatch("m00", result_o.m00, e.m00);
        if (result_o.m01 !== e.m01) report_mismatch("m01", result_o.m01, e.m01);
        if (result_o.m02 !== e.m02) report_mismatch("m02", result_o.m02, e.m02);
        if (result_o.m10 !== e.m10) report_mismatch("m10", result_o.m10, e.m10);
        if (result_o.m11 !== e.m11) report_mismatch("m11", result_o.m11, e.m11);
        if (result_o.m12 !== e.m12) report_mismatch("m12", result_o.m12, e.m12);
        if (result_o.m20 !== e.m20) report_mismatch("m20", result_o.m20, e.m20);
        if (result_o.m21 !== e.m21) report_mismatch("m21", result_o.m21, e.m21);
        if (result_o.m22 !== e.m22) report_mismatch("m22", result_o.m22, e.m22);
        if (result_o.last_out !== e.last_out)
          report_mismatch("last_out", 48'(result_o.last_out), 48'(e.last_out));
      end
      n_results++;
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WD_LIMIT) begin
      $display("Watchdog: no progress for %0d cycles", WD_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  task automatic send_item(cpm_in_t it);
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    matrix_q.push_back(placement_matrix(it));
    n_items++;
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic int rand_gap();
    int k;
    k = $urandom_range(0, 9);
    if (k < 6) return 0;
    if (k < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic wait_drained();
    start <= 1'b0;
    while (matrix_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic cpm_in_t make_item(logic [31:0] sx, sy, sz, ex, ey, ez, rad, int lst);
    cpm_in_t it;
    it.start_x = sx; it.start_y = sy; it.start_z = sz;
    it.end_x = ex; it.end_y = ey; it.end_z = ez;
    it.radius = rad; it.last_in = lst[0];
    return it;
  endfunction

  task automatic test_directed();
    logic [31:0] mx, mn;
    mx = 32'h7FFF_FFFF;
    mn = 32'h8000_0000;
    send_item(make_item(0, 0, 0, 0, 0, 0, 32'h0001_0000, 0));          // zero length
    send_item(make_item(5, 6, 7, 5, 6, 7, 32'hFFFF_FFFF, 1));          // zero length, max r
    send_item(make_item(0, 0, 0, 0, 0, 32'h0002_0000, 32'h0001_0000, 0)); // along +z
    send_item(make_item(0, 0, 32'h0002_0000, 0, 0, 0, 32'h0003_0000, 1)); // opposite +z
    send_item(make_item(0, 0, mx, 0, 0, mn, 32'hFFFF_FFFF, 0));        // opposite, longest
    send_item(make_item(0, 0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000, 0)); // along x
    send_item(make_item(0, 0, 0, 0, 32'hFFFF_0000, 0, 32'h0001_0000, 0)); // along -y
    send_item(make_item(mn, mn, mn, mx, mx, mx, 32'hFFFF_FFFF, 1));    // widest axis
    send_item(make_item(mx, mx, mx, mn, mn, mn, 32'hFFFF_FFFF, 0));
    send_item(make_item(mn, mx, mn, mx, mn, mx, 0, 1));                // radius zero
    send_item(make_item(mx, mn, 0, mn, mx, 1, 32'hFFFF_FFFF, 0));      // axis near xy plane
    send_item(make_item(0, 0, 1, 1, 0, 0, 32'h8000_0000, 1));          // tiny, tilted down
    send_item(make_item(0, 0, 0, 1, 1, 1, 32'hFFFF_FFFF, 0));
    send_item(make_item(0, 0, 0, 0, 1, -1, 32'h0000_0001, 1));
    send_item(make_item(mx, 0, 0, mx, 0, mn, 32'h7FFF_FFFF, 0));
    send_item(make_item(0, 0, 0, 3, 4, 0, 32'h0010_0000, 1));
    wait_drained();
  endtask

  task automatic test_random(int n, bit wide, bit gaps);
    cpm_in_t it;
    int      k;
    for (int i = 0; i < n; i++) begin
      it = make_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom_range(0, 1));
      k = $urandom_range(0, 9);
      if (!wide || k < 3) begin
        // modest coordinates around a random centre
        it.end_x = it.start_x + $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
        it.end_y = it.start_y + $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
        it.end_z = it.start_z + $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
        if ($urandom_range(0, 3) == 0) it.radius = $urandom_range(0, 32'h3_0000);
      end
      if (k == 9) begin
        it.end_x = it.start_x;
        it.end_y = it.start_y;
        if ($urandom_range(0, 1)) it.end_z = it.start_z;
      end
      send_item(it);
      if (gaps) idle_gap(rand_gap());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(250, 1'b0, 1'b1);
    wait_drained();
    test_random(150, 1'b1, 1'b0);
    test_random(N_RANDOM - 400, 1'b1, 1'b1);
    wait_drained();
    repeat (DRAIN) @(posedge clk_i);
    $display("Covered %0d cylinders and %0d matrices: %0d of zero length, %0d opposite to +z.",
             n_items, n_results, n_zero_len, n_opposite);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
